### rtl/core/swdrs_pkg.sv
// swdrs_pkg: shared types, register map, state and led codes for the
// swing display row sequencer. no dependencies.
package swdrs_pkg;

    localparam int FRAME_COUNT_WIDTH_DEF = 32;
    localparam int ROW_PERIOD_WIDTH_DEF  = 16;

    // logical rows = visible + 2 * overscan, at most 93
    localparam int LOGIC_W = 7;
    // divisor = 2 * logical rows, at most 186
    localparam int DIV_W   = 8;

    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOCK      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VISIBLE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OVERSCAN  = 3'd4;

    localparam logic [6:0]  THRESHOLD_RST = 7'd40;
    localparam logic [31:0] FRAME_MAX_RST = 32'd200000;
    localparam logic [15:0] LOCK_RST      = 16'd30000;
    localparam logic [5:0]  VISIBLE_RST   = 6'd16;
    localparam logic [3:0]  OVERSCAN_RST  = 4'd0;

    localparam logic [2:0] ST_UNKNOWN   = 3'd0;
    localparam logic [2:0] ST_LEFT_END  = 3'd1;
    localparam logic [2:0] ST_FORWARD   = 3'd2;
    localparam logic [2:0] ST_RIGHT_END = 3'd3;
    localparam logic [2:0] ST_BACKWARD  = 3'd4;

    localparam logic [1:0] LED_NONE  = 2'd0;
    localparam logic [1:0] LED_ROW   = 2'd1;
    localparam logic [1:0] LED_BLANK = 2'd2;

    typedef struct packed {
        logic [6:0]  return_threshold;
        logic [31:0] frame_max_ticks;
        logic [15:0] lock_ticks;
        logic [5:0]  rows_visible;
        logic [3:0]  rows_overscan;
    } t_cfg;

    typedef struct packed {
        logic       accept;
        logic       tick;
        logic       ignore;
        logic       stop;
        logic       start_fwd;
        logic       start_bwd;
        logic       timeout;
        logic       blank;
        logic [2:0] swing;
    } t_cmd;

    typedef struct packed {
        logic locked;
        logic mag_gt;
        logic mag_lt;
        logic pos_gt;
        logic neg_lt;
        logic acc_pos;
        logic frame_over;
        logic div_busy;
    } t_status;

endpackage

### rtl/core/swdrs_regs.sv
// swdrs_regs: apb-style configuration registers with read back.
// depends on swdrs_pkg.
module swdrs_regs import swdrs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.return_threshold <= THRESHOLD_RST;
            r_cfg.frame_max_ticks  <= FRAME_MAX_RST;
            r_cfg.lock_ticks       <= LOCK_RST;
            r_cfg.rows_visible     <= VISIBLE_RST;
            r_cfg.rows_overscan    <= OVERSCAN_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THRESHOLD: r_cfg.return_threshold <= pwdata[6:0];
                REG_FRAME_MAX: r_cfg.frame_max_ticks  <= pwdata;
                REG_LOCK:      r_cfg.lock_ticks       <= pwdata[15:0];
                REG_VISIBLE:   r_cfg.rows_visible     <= pwdata[5:0];
                REG_OVERSCAN:  r_cfg.rows_overscan    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_THRESHOLD: prdata = {25'd0, r_cfg.return_threshold};
            REG_FRAME_MAX: prdata = r_cfg.frame_max_ticks;
            REG_LOCK:      prdata = {16'd0, r_cfg.lock_ticks};
            REG_VISIBLE:   prdata = {26'd0, r_cfg.rows_visible};
            REG_OVERSCAN:  prdata = {28'd0, r_cfg.rows_overscan};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

### rtl/core/swdrs_ctrl.sv
// swdrs_ctrl: swing state machine, transaction sequencing and output valid.
// depends on swdrs_pkg; drives commands into swdrs_datapath.
module swdrs_ctrl import swdrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_opcode,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic       r_seq, n_seq;
    logic [2:0] r_swing, n_swing;
    logic       r_out_valid;
    logic       w_accept, w_sample;
    logic       w_stop, w_fwd, w_bwd, w_blank, w_timeout;

    assign o_in_ready  = (r_seq == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_sample    = w_accept && !i_opcode && !i_status.locked;

    always_comb begin
        n_swing = r_swing;
        w_stop  = 1'b0;
        w_fwd   = 1'b0;
        w_bwd   = 1'b0;
        w_blank = 1'b0;
        unique case (r_swing)
            ST_UNKNOWN: begin
                if (i_status.mag_gt) begin
                    w_stop  = 1'b1;
                    n_swing = i_status.acc_pos ? ST_RIGHT_END : ST_LEFT_END;
                end
            end
            ST_LEFT_END: begin
                if (i_status.mag_lt) begin
                    w_fwd   = 1'b1;
                    n_swing = ST_FORWARD;
                end
            end
            ST_RIGHT_END: begin
                if (i_status.mag_lt) begin
                    w_bwd   = 1'b1;
                    n_swing = ST_BACKWARD;
                end
            end
            ST_FORWARD: begin
                if (i_status.pos_gt) begin
                    w_stop  = 1'b1;
                    w_blank = 1'b1;
                    n_swing = ST_RIGHT_END;
                end
            end
            ST_BACKWARD: begin
                if (i_status.neg_lt) begin
                    w_stop  = 1'b1;
                    w_blank = 1'b1;
                    n_swing = ST_LEFT_END;
                end
            end
            default: n_swing = ST_UNKNOWN;
        endcase
        // begin_frame clears the frame counter, so no timeout then
        w_timeout = i_status.frame_over && !w_fwd && !w_bwd;
        if (w_timeout) begin
            n_swing = ST_UNKNOWN;
        end
    end

    always_comb begin
        o_cmd.accept    = w_accept;
        o_cmd.tick      = w_accept && i_opcode;
        o_cmd.ignore    = w_accept && !i_opcode && i_status.locked;
        o_cmd.stop      = w_sample && w_stop;
        o_cmd.start_fwd = w_sample && w_fwd;
        o_cmd.start_bwd = w_sample && w_bwd;
        o_cmd.timeout   = w_sample && w_timeout;
        o_cmd.blank     = w_sample && w_blank;
        o_cmd.swing     = w_sample ? n_swing : r_swing;
    end

    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            S_IDLE: if (o_cmd.start_fwd || o_cmd.start_bwd) n_seq = S_DIV;
            S_DIV:  if (!i_status.div_busy) n_seq = S_IDLE;
            default: n_seq = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= S_IDLE;
            r_swing     <= ST_UNKNOWN;
            r_out_valid <= 1'b0;
        end else begin
            r_seq   <= n_seq;
            r_swing <= o_cmd.swing;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/swdrs_datapath.sv
// swdrs_datapath: frame and row counters, row stepping, serial divider for
// the row period and the output payload registers. depends on swdrs_pkg.
module swdrs_datapath import swdrs_pkg::*; #(
    parameter int FRAME_COUNT_WIDTH = FRAME_COUNT_WIDTH_DEF,
    parameter int ROW_PERIOD_WIDTH  = ROW_PERIOD_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    input  logic signed [7:0] i_accel_x,
    output t_status           o_status,
    output logic [1:0]        o_led_command,
    output logic [7:0]        o_row_index,
    output logic [2:0]        o_motion_state,
    output logic              o_sample_ignored
);

    localparam int FW = FRAME_COUNT_WIDTH;
    localparam int PW = ROW_PERIOD_WIDTH;
    localparam int QW = (FW > PW) ? FW : PW;
    localparam int CW = $clog2(FW + 1);

    logic [FW-1:0] r_frame_count, n_frame_count;
    logic          r_frame_running, n_frame_running;
    logic          r_lock, n_lock;
    logic [PW-1:0] r_tick_count, n_tick_count;
    logic [PW-1:0] r_period;
    logic          r_row_run, n_row_run;
    logic [7:0]    r_row, n_row;
    logic          r_backward, n_backward;
    logic          r_gap, n_gap;

    logic [1:0]    n_led;
    logic [7:0]    n_row_out;

    logic          r_div_busy;
    logic [CW-1:0] r_div_cnt;
    logic [FW-1:0] r_dvd;
    logic [DIV_W-1:0] r_rem, r_dsr;
    logic [DIV_W:0]   w_trial;
    logic             w_bit;
    logic [DIV_W-1:0] w_rem_next;
    logic [QW-1:0]    w_q_ext;
    logic [PW-1:0]    w_q_sat;

    logic [LOGIC_W-1:0] w_logic_rows, w_win_hi;
    logic [DIV_W-1:0]   w_divisor;
    logic signed [8:0]  w_acc, w_th, w_mag;
    logic [FW-1:0]      w_fc_tick;
    logic [7:0]         w_row_step;
    logic               w_begin;

    assign w_logic_rows = LOGIC_W'(i_cfg.rows_visible) + {2'd0, i_cfg.rows_overscan, 1'b0};
    assign w_win_hi     = LOGIC_W'(i_cfg.rows_visible) + LOGIC_W'(i_cfg.rows_overscan);
    assign w_divisor    = {w_logic_rows, 1'b0};
    assign w_begin      = i_cmd.start_fwd || i_cmd.start_bwd;

    assign w_acc = 9'(i_accel_x);
    assign w_th  = $signed({2'd0, i_cfg.return_threshold});
    assign w_mag = w_acc[8] ? -w_acc : w_acc;

    always_comb begin
        o_status.locked     = r_lock;
        o_status.mag_gt     = w_mag > w_th;
        o_status.mag_lt     = w_mag < w_th;
        o_status.pos_gt     = w_acc > w_th;
        o_status.neg_lt     = w_acc < -w_th;
        o_status.acc_pos    = !w_acc[8] && (w_acc != 9'sd0);
        o_status.frame_over = 32'(r_frame_count) > i_cfg.frame_max_ticks;
        o_status.div_busy   = r_div_busy;
    end

    assign w_fc_tick  = (r_frame_running && r_frame_count != {FW{1'b1}})
                        ? r_frame_count + FW'(1) : r_frame_count;
    assign w_row_step = r_backward ? r_row - 8'd1 : r_row + 8'd1;

    always_comb begin
        n_frame_count   = r_frame_count;
        n_frame_running = r_frame_running;
        n_lock          = r_lock;
        n_tick_count    = r_tick_count;
        n_row_run       = r_row_run;
        n_row           = r_row;
        n_backward      = r_backward;
        n_gap           = r_gap;
        n_led           = LED_NONE;
        n_row_out       = 8'd0;
        if (i_cmd.tick) begin
            n_frame_count = w_fc_tick;
            if (r_lock && w_fc_tick >= FW'(i_cfg.lock_ticks)) begin
                n_lock = 1'b0;
            end
            if (r_row_run) begin
                if (r_tick_count >= r_period) begin
                    n_tick_count = '0;
                    if (!r_gap) begin
                        if (r_row >= {4'd0, i_cfg.rows_overscan} &&
                            r_row < {1'b0, w_win_hi}) begin
                            n_led     = LED_ROW;
                            n_row_out = r_row;
                        end else begin
                            n_led = LED_BLANK;
                        end
                        n_gap = 1'b1;
                    end else begin
                        n_led = LED_BLANK;
                        n_row = w_row_step;
                        n_gap = 1'b0;
                        if (w_row_step >= {1'b0, w_logic_rows}) begin
                            n_row_run = 1'b0;
                        end
                    end
                end else begin
                    n_tick_count = r_tick_count + PW'(1);
                end
            end
        end else begin
            if (i_cmd.stop) begin
                n_frame_running = 1'b0;
                n_row_run       = 1'b0;
            end
            if (i_cmd.start_fwd) begin
                n_backward = 1'b0;
                n_row      = 8'd0;
                n_gap      = 1'b0;
            end
            if (i_cmd.start_bwd) begin
                n_backward = 1'b1;
                n_row      = {1'b0, w_logic_rows};
                n_gap      = 1'b1;
            end
            if (w_begin) begin
                n_frame_count   = '0;
                n_tick_count    = '0;
                n_frame_running = 1'b1;
                n_row_run       = 1'b1;
                n_lock          = 1'b1;
            end
            if (i_cmd.timeout) begin
                n_frame_count   = '0;
                n_frame_running = 1'b1;
            end
            if (i_cmd.blank || i_cmd.timeout) begin
                n_led = LED_BLANK;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    assign w_trial    = {r_rem, r_dvd[FW-1]};
    assign w_bit      = w_trial >= {1'b0, r_dsr};
    assign w_rem_next = w_bit ? DIV_W'(w_trial - {1'b0, r_dsr}) : w_trial[DIV_W-1:0];
    assign w_q_ext    = QW'(r_dvd);
    assign w_q_sat    = (|(w_q_ext >> PW)) ? {PW{1'b1}} : w_q_ext[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_period   <= '0;
        end else if (w_begin) begin
            if (w_divisor == '0) begin
                r_period <= {PW{1'b1}};
            end else begin
                r_div_busy <= 1'b1;
            end
        end else if (r_div_busy) begin
            if (r_div_cnt == '0) begin
                r_period   <= w_q_sat;
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_begin) begin
            r_dvd     <= r_frame_count;
            r_rem     <= '0;
            r_dsr     <= w_divisor;
            r_div_cnt <= CW'(FW);
        end else if (r_div_busy && r_div_cnt != '0) begin
            r_dvd     <= {r_dvd[FW-2:0], w_bit};
            r_rem     <= w_rem_next;
            r_div_cnt <= r_div_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count   <= '0;
            r_frame_running <= 1'b1;
            r_lock          <= 1'b0;
            r_tick_count    <= '0;
            r_row_run       <= 1'b0;
            r_row           <= 8'd0;
            r_backward      <= 1'b0;
            r_gap           <= 1'b0;
        end else if (i_cmd.accept && !i_cmd.ignore) begin
            r_frame_count   <= n_frame_count;
            r_frame_running <= n_frame_running;
            r_lock          <= n_lock;
            r_tick_count    <= n_tick_count;
            r_row_run       <= n_row_run;
            r_row           <= n_row;
            r_backward      <= n_backward;
            r_gap           <= n_gap;
        end
    end

    // payload of the result transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            o_led_command    <= i_cmd.ignore ? LED_NONE : n_led;
            o_row_index      <= i_cmd.ignore ? 8'd0 : n_row_out;
            o_motion_state   <= i_cmd.swing;
            o_sample_ignored <= i_cmd.ignore;
        end
    end

endmodule

### rtl/core/swing_display_row_sequencer.sv
// swing_display_row_sequencer: top level of the swing display row sequencer.
// depends on swdrs_pkg, swdrs_regs, swdrs_ctrl and swdrs_datapath.
//
// One transaction in (a timer tick or a signed X acceleration sample) gives
// exactly one result transaction out: led command, row index, motion state
// after the item and a flag for samples dropped during the lock time. For
// ticks and most samples the result sits in an output register and a new
// item is taken in the cycle it is collected. A sample that ends a return
// phase starts the serial row-period divider, one quotient bit per cycle,
// so the block takes no new item until the division is done and the
// control sequencer is back in idle.
// Configuration is an apb-style port, registers at byte address 4*index.
module swing_display_row_sequencer import swdrs_pkg::*; #(
    parameter int FRAME_COUNT_WIDTH = FRAME_COUNT_WIDTH_DEF,
    parameter int ROW_PERIOD_WIDTH  = ROW_PERIOD_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic signed [7:0] i_accel_x,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_led_command,
    output logic [7:0]        o_row_index,
    output logic [2:0]        o_motion_state,
    output logic              o_sample_ignored
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    swdrs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    swdrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    swdrs_datapath #(
        .FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH),
        .ROW_PERIOD_WIDTH  (ROW_PERIOD_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .i_accel_x        (i_accel_x),
        .o_status         (w_status),
        .o_led_command    (o_led_command),
        .o_row_index      (o_row_index),
        .o_motion_state   (o_motion_state),
        .o_sample_ignored (o_sample_ignored)
    );

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.div_busy |-> !o_in_ready)
        else $error("input taken while divider busy");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("no result after input transaction");

    a_row_only_when_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_led_command != LED_ROW) |-> (o_row_index == 8'd0))
        else $error("row index set without show command");

endmodule
